>>> hdl/pdf_pkg.sv
package pdf_pkg;

    localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
    localparam logic [15:0] CRC_INIT      = 16'h1D0F;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_TOP       = 16'h8000;
    localparam logic [7:0]  TYPE_SECOND   = 8'h31;
    localparam int          TYPE_COUNT    = 5;
    localparam int          PDF_QUEUE_DEPTH = 2;

    // first character of each known type: s g i o y
    localparam logic [7:0] TYPE_FIRST [TYPE_COUNT] = '{8'h73, 8'h67, 8'h69, 8'h6F, 8'h79};

    localparam logic [2:0] ROLE_HUNT     = 3'd0;
    localparam logic [2:0] ROLE_PREAMBLE = 3'd1;
    localparam logic [2:0] ROLE_TYPE     = 3'd2;
    localparam logic [2:0] ROLE_LENGTH   = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD  = 3'd4;
    localparam logic [2:0] ROLE_CRC      = 3'd5;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] role;
        logic       start;
        logic [2:0] ftype;
        logic       last;
    } pdf_item_t;

    // one byte of crc-16, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // returns {hit, index}
    function automatic logic [3:0] type_lookup(input logic [7:0] first, input logic [7:0] second);
        logic [3:0] r;
        r = 4'b0000;
        for (int i = TYPE_COUNT - 1; i >= 0; i--) begin
            if (TYPE_FIRST[i] == first && second == TYPE_SECOND) begin
                r = {1'b1, 3'(i)};
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/pdf_in_if.sv
interface pdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

>>> hdl/pdf_out_if.sv
interface pdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] byte_role;
    logic       frame_start;
    logic [2:0] frame_type;
    logic       frame_end;
    logic       crc_ok;

    modport source (output valid, output out_byte, output byte_role, output frame_start,
                    output frame_type, output frame_end, output crc_ok, input ready);
    modport sink (input valid, input out_byte, input byte_role, input frame_start,
                  input frame_type, input frame_end, input crc_ok, output ready);
endinterface

>>> hdl/preamble_packet_deframer_crc16.sv
// preamble packet deframer with crc-16 check
// rx carries one received byte per transfer (in_byte); tx carries one result
// per byte: the byte, its role (hunting, preamble, type, length, payload, crc),
// frame_start on a matched second type byte with frame_type, and frame_end
// with crc_ok on the last crc byte of a frame
// a byte taken from rx passes through the queue and the output register to tx
// throughput: one byte per cycle while tx.ready stays high; the front classifier,
// the queue and the byte-wide crc update in the back each run once a cycle
// the receiver may stall at will: the output register holds its transfer and
// the small queue absorbs the bytes in flight, rx.ready drops only when the
// queue is full and nothing leaves it
// reset (rst_n low, asynchronous) empties queue and output register, returns
// the front to preamble hunting and loads the crc with its initial value
module preamble_packet_deframer_crc16 #(
    parameter int QUEUE_DEPTH = pdf_pkg::PDF_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    pdf_in_if.sink    rx,
    pdf_out_if.source tx
);
    import pdf_pkg::*;

    // front to queue
    pdf_item_t front_item;
    logic      front_push;
    logic      q_ready;

    // queue to back
    pdf_item_t back_item;
    logic      q_empty;
    logic      back_pop;

    // classifier: hunting, header and frame position tracking
    pdf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .q_ready (q_ready),
        .push    (front_push),
        .item    (front_item)
    );

    // decoupling queue between classifier and crc/output stage
    pdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_item  (front_item),
        .push_ready (q_ready),
        .pop        (back_pop),
        .pop_item   (back_item),
        .empty      (q_empty)
    );

    // crc accumulation, verdict and output register
    pdf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (q_empty),
        .item  (back_item),
        .pop   (back_pop),
        .tx    (tx)
    );

endmodule

>>> hdl/pdf_front.sv
module pdf_front (
    input  logic                clk,
    input  logic                rst_n,
    pdf_in_if.sink              rx,
    input  logic                q_ready,
    output logic                push,
    output pdf_pkg::pdf_item_t  item
);
    import pdf_pkg::*;

    typedef enum logic [7:0] {
        S_PRE0 = 8'b0000_0001,
        S_PRE1 = 8'b0000_0010,
        S_TYP0 = 8'b0000_0100,
        S_TYP1 = 8'b0000_1000,
        S_LEN  = 8'b0001_0000,
        S_PAY  = 8'b0010_0000,
        S_CRCH = 8'b0100_0000,
        S_CRCL = 8'b1000_0000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [7:0]   first_reg, first_next;
    logic [7:0]   remain_reg, remain_next;
    logic [2:0]   type_reg, type_next;
    logic [3:0]   lookup;
    logic [7:0]   b;

    assign rx.ready = q_ready;
    assign push     = rx.valid && q_ready;
    assign b        = rx.in_byte;
    assign lookup   = type_lookup(first_reg, b);

    always_comb
    begin
        state_next  = state_reg;
        first_next  = first_reg;
        remain_next = remain_reg;
        type_next   = type_reg;
        item.data   = b;
        item.role   = ROLE_HUNT;
        item.start  = 1'b0;
        item.ftype  = 3'd0;
        item.last   = 1'b0;
        case (state_reg)
            S_PRE0:
            begin
                if (b == PREAMBLE_BYTE) begin
                    item.role  = ROLE_PREAMBLE;
                    state_next = S_PRE1;
                end
            end
            S_PRE1:
            begin
                if (b == PREAMBLE_BYTE) begin
                    item.role  = ROLE_PREAMBLE;
                    state_next = S_TYP0;
                end
                else begin
                    state_next = S_PRE0;
                end
            end
            S_TYP0:
            begin
                item.role  = ROLE_TYPE;
                first_next = b;
                state_next = S_TYP1;
            end
            S_TYP1:
            begin
                state_next = S_PRE0;
                if (lookup[3]) begin
                    item.role  = ROLE_TYPE;
                    item.start = 1'b1;
                    item.ftype = lookup[2:0];
                    type_next  = lookup[2:0];
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                item.role   = ROLE_LENGTH;
                item.ftype  = type_reg;
                remain_next = b;
                state_next  = (b == 8'd0) ? S_CRCH : S_PAY;
            end
            S_PAY:
            begin
                item.role   = ROLE_PAYLOAD;
                item.ftype  = type_reg;
                remain_next = remain_reg - 8'd1;
                if (remain_reg == 8'd1) begin
                    state_next = S_CRCH;
                end
            end
            S_CRCH:
            begin
                item.role  = ROLE_CRC;
                item.ftype = type_reg;
                state_next = S_CRCL;
            end
            S_CRCL:
            begin
                item.role  = ROLE_CRC;
                item.ftype = type_reg;
                item.last  = 1'b1;
                state_next = S_PRE0;
            end
            default:
            begin
                state_next = S_PRE0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_PRE0;
            first_reg  <= 8'd0;
            remain_reg <= 8'd0;
            type_reg   <= 3'd0;
        end
        else if (push) begin
            state_reg  <= state_next;
            first_reg  <= first_next;
            remain_reg <= remain_next;
            type_reg   <= type_next;
        end
    end

`ifndef ASSERT_OFF
    a_start_is_type: assert property (@(posedge clk) disable iff (!rst_n)
        push && item.start |=> state_reg == S_LEN)
        else $error("frame start did not enter length state");
`endif

endmodule

>>> hdl/pdf_queue.sv
module pdf_queue #(
    parameter int DEPTH = pdf_pkg::PDF_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pdf_pkg::pdf_item_t  push_item,
    output logic                push_ready,
    input  logic                pop,
    output pdf_pkg::pdf_item_t  pop_item,
    output logic                empty
);
    import pdf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pdf_item_t      mem_reg [DEPTH];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [CW-1:0]  count_reg;
    logic           full;

    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign push_ready = !full || pop;
    assign pop_item   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");
`endif

endmodule

>>> hdl/pdf_back.sv
module pdf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  pdf_pkg::pdf_item_t  item,
    output logic                pop,
    pdf_out_if.source           tx
);
    import pdf_pkg::*;

    logic        valid_reg;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  high_reg;
    logic [7:0]  byte_reg;
    logic [2:0]  role_reg;
    logic        start_reg;
    logic [2:0]  type_reg;
    logic        end_reg;
    logic        ok_reg, ok_next;

    assign pop = !empty && (!valid_reg || tx.ready);

    always_comb
    begin
        crc_next = crc_reg;
        ok_next  = 1'b0;
        case (item.role)
            ROLE_TYPE:    crc_next = item.start ? crc_feed(crc_reg, item.data)
                                                : crc_feed(CRC_INIT, item.data);
            ROLE_LENGTH:  crc_next = crc_feed(crc_reg, item.data);
            ROLE_PAYLOAD: crc_next = crc_feed(crc_reg, item.data);
            ROLE_CRC:     ok_next  = item.last && ({high_reg, item.data} == crc_reg);
            default:      crc_next = crc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            crc_reg   <= CRC_INIT;
            high_reg  <= 8'd0;
        end
        else begin
            if (pop) begin
                valid_reg <= 1'b1;
                crc_reg   <= crc_next;
                if (item.role == ROLE_CRC && !item.last) begin
                    high_reg <= item.data;
                end
            end
            else if (tx.ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            byte_reg  <= item.data;
            role_reg  <= item.role;
            start_reg <= item.start;
            type_reg  <= item.ftype;
            end_reg   <= item.last;
            ok_reg    <= ok_next;
        end
    end

    assign tx.valid       = valid_reg;
    assign tx.out_byte    = byte_reg;
    assign tx.byte_role   = role_reg;
    assign tx.frame_start = start_reg;
    assign tx.frame_type  = type_reg;
    assign tx.frame_end   = end_reg;
    assign tx.crc_ok      = ok_reg;

`ifndef ASSERT_OFF
    a_end_on_crc: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && end_reg |-> role_reg == ROLE_CRC)
        else $error("frame end outside crc byte");
    a_ok_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && ok_reg |-> end_reg)
        else $error("crc verdict without frame end");
`endif

endmodule
